FILE: rtl/plni_pkg.sv
// Shared types and constants of the periodic lattice neighbour index unit.
`default_nettype none

package plni_pkg;

    localparam int WORD_W     = 24;
    localparam int EXT_W      = 7;
    localparam int COORD_W    = 6;
    localparam int DIRECTIONS = 4;
    localparam int DIR_W      = 2;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = WORD_W / DIV_STEPS;

    localparam logic [DIR_W-1:0] DIR_X = 2'd0;
    localparam logic [DIR_W-1:0] DIR_Y = 2'd1;
    localparam logic [DIR_W-1:0] DIR_Z = 2'd2;
    localparam logic [DIR_W-1:0] DIR_T = 2'd3;

    localparam logic [EXT_W-1:0] EXTENT_RESET = 7'd8;

    typedef struct packed {
        logic [WORD_W-1:0] site;
        logic [DIR_W-1:0]  direction;
    } plni_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [COORD_W-1:0] coord_t;
        logic               parity;
        logic [WORD_W-1:0]  forward_neighbor;
        logic [WORD_W-1:0]  backward_neighbor;
        logic               out_of_range;
    } plni_out_t;

    // one item in flight through the divider chain
    typedef struct packed {
        logic [WORD_W-1:0] site;
        logic [DIR_W-1:0]  dir;
        logic [EXT_W-1:0]  c0;
        logic [EXT_W-1:0]  c1;
        logic [EXT_W-1:0]  rem;
        logic [WORD_W-1:0] work;
    } plni_div_t;

endpackage

`default_nettype wire

FILE: rtl/periodic_lattice_neighbor_index_unit.sv
// Pipeline from start to done: 9 divider stages, then 4 neighbour stages.
// Throughput: one item per cycle; busy is never raised.
// Rate set by the divider chain: three divisions by the extents, 8 quotient bits per stage.
// Reset: all extents return to 8 and the pipeline empties; no result is pending.
// Output is a one-cycle done strobe; the receiver cannot stall.
`default_nettype none

module periodic_lattice_neighbor_index_unit #(
    parameter int MAX_EXTENT = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire plni_pkg::plni_in_t         item,
    output logic                            done,
    output plni_pkg::plni_out_t             result,
    input  wire logic                       cfg_we,
    input  wire logic [plni_pkg::DIR_W-1:0] cfg_index,
    input  wire logic [plni_pkg::EXT_W-1:0] cfg_data
);
    import plni_pkg::*;

    localparam int DIV_TOTAL = 3 * DIV_STAGES;
    localparam int STRIDE_W  = 3 * EXT_W;
    localparam int WRAP_W    = STRIDE_W + EXT_W;

    typedef struct packed {
        logic [WORD_W-1:0]   site;
        logic [DIR_W-1:0]    dir;
        plni_out_t           res;
        logic                last;
        logic                first;
        logic [EXT_W-1:0]    nm1;
        logic [STRIDE_W-1:0] stride;
        logic [WORD_W-1:0]   wrap;
    } post_t;

    logic [EXT_W-1:0] extent_reg [DIRECTIONS];
    logic [EXT_W-1:0] eff [DIRECTIONS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIRECTIONS; i++)
            begin
                extent_reg[i] <= EXTENT_RESET;
            end
        end
        else if (cfg_we)
        begin
            extent_reg[cfg_index] <= cfg_data;
        end
    end

    // zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        for (int i = 0; i < DIRECTIONS; i++)
        begin
            if (extent_reg[i] == '0)
            begin
                eff[i] = 7'd1;
            end
            else if (int'(extent_reg[i]) > MAX_EXTENT)
            begin
                eff[i] = EXT_W'(MAX_EXTENT);
            end
            else
            begin
                eff[i] = extent_reg[i];
            end
        end
    end

    assign busy = 1'b0;

    // divider chain: site / X, then / Y, then / Z
    logic [DIV_TOTAL-1:0] div_v;
    plni_div_t            div_q [DIV_TOTAL];

    for (genvar j = 0; j < DIV_TOTAL; j++)
    begin : g_div
        localparam int D = j / DIV_STAGES;
        localparam int K = j % DIV_STAGES;
        logic      stage_v;
        plni_div_t stage_in;

        if (j == 0)
        begin : g_first
            always_comb
            begin
                stage_in      = '0;
                stage_in.site = item.site;
                stage_in.dir  = item.direction;
                stage_in.work = item.site;
            end
            assign stage_v = start && !busy;
        end
        else if (K == 0)
        begin : g_next_div
            always_comb
            begin
                stage_in     = div_q[j-1];
                stage_in.rem = '0;
                if (D == 1)
                begin
                    stage_in.c0 = div_q[j-1].rem;
                end
                else
                begin
                    stage_in.c1 = div_q[j-1].rem;
                end
            end
            assign stage_v = div_v[j-1];
        end
        else
        begin : g_cont
            assign stage_in = div_q[j-1];
            assign stage_v  = div_v[j-1];
        end

        plni_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_v),
            .in_data   (stage_in),
            .divisor   (eff[D]),
            .out_valid (div_v[j]),
            .out_data  (div_q[j])
        );
    end

    // neighbour stages
    logic  p1_valid_reg, p2_valid_reg, p3_valid_reg, done_reg;
    post_t p1_reg, p2_reg, p3_reg;
    post_t p1_next, p2_next, p3_next;
    plni_out_t result_reg, result_next;

    always_comb
    begin
        plni_div_t        dq;
        logic [EXT_W-1:0] c2;
        logic [EXT_W-1:0] c3;
        logic [EXT_W-1:0] cdir;
        logic [2*EXT_W-1:0] s2;
        dq   = div_q[DIV_TOTAL-1];
        c2   = dq.rem;
        c3   = dq.work[EXT_W-1:0];
        s2   = (2*EXT_W)'(eff[0]) * (2*EXT_W)'(eff[1]);
        unique case (dq.dir)
            DIR_X: cdir = dq.c0;
            DIR_Y: cdir = dq.c1;
            DIR_Z: cdir = c2;
            DIR_T: cdir = c3;
            default: cdir = dq.c0;
        endcase
        p1_next                  = '0;
        p1_next.site             = dq.site;
        p1_next.dir              = dq.dir;
        p1_next.res.coord_x      = dq.c0[COORD_W-1:0];
        p1_next.res.coord_y      = dq.c1[COORD_W-1:0];
        p1_next.res.coord_z      = c2[COORD_W-1:0];
        p1_next.res.coord_t      = c3[COORD_W-1:0];
        p1_next.res.parity       = dq.c0[0] ^ dq.c1[0] ^ c2[0] ^ c3[0];
        p1_next.res.out_of_range = (dq.work >= {{(WORD_W-EXT_W){1'b0}}, eff[3]});
        p1_next.nm1              = eff[dq.dir] - 7'd1;
        p1_next.last             = (cdir == p1_next.nm1);
        p1_next.first            = (cdir == '0);
        p1_next.stride           = {{(STRIDE_W-2*EXT_W){1'b0}}, s2};
    end

    always_comb
    begin
        logic [STRIDE_W-1:0] s3;
        s3      = p1_reg.stride * STRIDE_W'(eff[2]);
        p2_next = p1_reg;
        unique case (p1_reg.dir)
            DIR_X: p2_next.stride = STRIDE_W'(1);
            DIR_Y: p2_next.stride = {{(STRIDE_W-EXT_W){1'b0}}, eff[0]};
            DIR_Z: p2_next.stride = p1_reg.stride;
            DIR_T: p2_next.stride = s3;
            default: p2_next.stride = STRIDE_W'(1);
        endcase
    end

    always_comb
    begin
        logic [WRAP_W-1:0] w;
        w            = WRAP_W'(p2_reg.stride) * WRAP_W'(p2_reg.nm1);
        p3_next      = p2_reg;
        p3_next.wrap = w[WORD_W-1:0];
    end

    always_comb
    begin
        logic [WORD_W-1:0] step;
        step        = WORD_W'(p3_reg.stride);
        result_next = p3_reg.res;
        if (p3_reg.res.out_of_range)
        begin
            result_next              = '0;
            result_next.out_of_range = 1'b1;
        end
        else
        begin
            result_next.forward_neighbor  = p3_reg.last  ? p3_reg.site - p3_reg.wrap
                                                         : p3_reg.site + step;
            result_next.backward_neighbor = p3_reg.first ? p3_reg.site + p3_reg.wrap
                                                         : p3_reg.site - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= div_v[DIV_TOTAL-1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            done_reg     <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        p3_reg     <= p3_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/plni_div_stage.sv
// One registered stage of the restoring divider: DIV_STEPS quotient bits per stage.
`default_nettype none

module plni_div_stage (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire plni_pkg::plni_div_t       in_data,
    input  wire logic [plni_pkg::EXT_W-1:0] divisor,
    output logic                           out_valid,
    output plni_pkg::plni_div_t            out_data
);
    import plni_pkg::*;

    logic      valid_reg;
    plni_div_t data_reg;
    plni_div_t data_next;

    always_comb
    begin
        logic [EXT_W-1:0]  rem_v;
        logic [WORD_W-1:0] work_v;
        logic [EXT_W:0]    trial;
        logic              ge;
        rem_v  = in_data.rem;
        work_v = in_data.work;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial  = {rem_v, work_v[WORD_W-1]};
            ge     = (trial >= {1'b0, divisor});
            work_v = {work_v[WORD_W-2:0], ge};
            if (ge)
            begin
                trial = trial - {1'b0, divisor};
            end
            rem_v = trial[EXT_W-1:0];
        end
        data_next      = in_data;
        data_next.rem  = rem_v;
        data_next.work = work_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: tb/tb_periodic_lattice_neighbor_index_unit.sv
// Self-checking bench for the periodic lattice neighbour index unit.
`timescale 1ns / 1ps

module tb_periodic_lattice_neighbor_index_unit;
    import plni_pkg::*;

    localparam int LATENCY     = 13;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_EXT     = 64;
    localparam int RANDOM_SETS = 6;
    localparam int SET_ITEMS   = 106;
    localparam int MAX_REPORTS = 40;

    localparam logic [DIR_W-1:0] REG_EXTENT_X = 2'd0;
    localparam logic [DIR_W-1:0] REG_EXTENT_Y = 2'd1;
    localparam logic [DIR_W-1:0] REG_EXTENT_Z = 2'd2;
    localparam logic [DIR_W-1:0] REG_EXTENT_T = 2'd3;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    plni_in_t         item      = '0;
    logic             done;
    plni_out_t        result;
    logic             cfg_we    = 1'b0;
    logic [DIR_W-1:0] cfg_index = '0;
    logic [EXT_W-1:0] cfg_data  = '0;

    logic [EXT_W-1:0] extent_reg [DIRECTIONS];
    plni_out_t        pending [$];
    int               sender_idle_pct = 0;
    int               errors          = 0;
    int               items_sent      = 0;
    int               outside_sent    = 0;
    int               results_seen    = 0;
    int               settings_used   = 0;
    int               idle_cycles     = 0;

    periodic_lattice_neighbor_index_unit #(
        .MAX_EXTENT(MAX_EXT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned effective_extent(input logic [EXT_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (raw > MAX_EXT)
            return MAX_EXT;
        return raw;
    endfunction

    function automatic longint unsigned lattice_volume();
        longint unsigned vol;
        vol = 1;
        for (int i = 0; i < DIRECTIONS; i++)
            vol = vol * effective_extent(extent_reg[i]);
        return vol;
    endfunction

    function automatic plni_out_t predict_neighbours(input plni_in_t it);
        longint unsigned n [DIRECTIONS];
        longint unsigned c [DIRECTIONS];
        longint unsigned m [DIRECTIONS];
        longint unsigned s;
        longint unsigned fwd;
        longint unsigned bwd;
        plni_out_t       r;
        r = '0;
        for (int i = 0; i < DIRECTIONS; i++)
            n[i] = effective_extent(extent_reg[i]);
        if (it.site >= lattice_volume())
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        s = it.site;
        for (int i = 0; i < DIRECTIONS - 1; i++)
        begin
            c[i] = s % n[i];
            s    = s / n[i];
        end
        c[DIRECTIONS-1] = s;
        m = c;
        m[it.direction] = (c[it.direction] + 1) % n[it.direction];
        fwd = m[0] + n[0] * (m[1] + n[1] * (m[2] + n[2] * m[3]));
        m[it.direction] = (c[it.direction] + n[it.direction] - 1) % n[it.direction];
        bwd = m[0] + n[0] * (m[1] + n[1] * (m[2] + n[2] * m[3]));
        r.coord_x           = COORD_W'(c[0]);
        r.coord_y           = COORD_W'(c[1]);
        r.coord_z           = COORD_W'(c[2]);
        r.coord_t           = COORD_W'(c[3]);
        r.parity            = 1'((c[0] + c[1] + c[2] + c[3]) & 1);
        r.forward_neighbor  = WORD_W'(fwd);
        r.backward_neighbor = WORD_W'(bwd);
        r.out_of_range      = 1'b0;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // results are checked in order against the expected queue
    always @(posedge clk)
    begin : check_results
        plni_out_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none expected, expected none actual 0x%0h",
                             $time, result);
            end
            else
            begin
                want = pending.pop_front();
                check_field("coord_x", want.coord_x, result.coord_x);
                check_field("coord_y", want.coord_y, result.coord_y);
                check_field("coord_z", want.coord_z, result.coord_z);
                check_field("coord_t", want.coord_t, result.coord_t);
                check_field("parity", want.parity, result.parity);
                check_field("forward_neighbor", want.forward_neighbor,
                            result.forward_neighbor);
                check_field("backward_neighbor", want.backward_neighbor,
                            result.backward_neighbor);
                check_field("out_of_range", want.out_of_range, result.out_of_range);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_site(input logic [WORD_W-1:0] site, input logic [DIR_W-1:0] dir);
        plni_in_t it;
        it.site      = site;
        it.direction = dir;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending.push_back(predict_neighbours(it));
        items_sent++;
        if (it.site >= lattice_volume())
            outside_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    task automatic write_extent(input logic [DIR_W-1:0] idx, input logic [EXT_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        extent_reg[idx] = val;
    endtask

    task automatic set_extents(input logic [EXT_W-1:0] ex, input logic [EXT_W-1:0] ey,
                               input logic [EXT_W-1:0] ez, input logic [EXT_W-1:0] et);
        write_extent(REG_EXTENT_X, ex);
        write_extent(REG_EXTENT_Y, ey);
        write_extent(REG_EXTENT_Z, ez);
        write_extent(REG_EXTENT_T, et);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [EXT_W-1:0] pick_extent();
        case ($urandom_range(7))
            0: return '0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            4: return EXT_W'($urandom_range(127, 65));
            default: return EXT_W'($urandom_range(64, 1));
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pick_site();
        longint unsigned vol;
        vol = lattice_volume();
        case ($urandom_range(9))
            0: return WORD_W'($urandom);
            1: return (vol > 24'hFFFFFF) ? '1 : WORD_W'(vol);
            2: return WORD_W'(vol - 1);
            default: return WORD_W'($urandom_range(32'(vol - 1)));
        endcase
    endfunction

    // reset extents of 8: corners, wrap on each axis, sites past the volume
    task automatic test_reset_extents();
        send_site(24'd0, DIR_X);
        send_site(24'd0, DIR_Y);
        send_site(24'd7, DIR_X);
        send_site(24'd4095, DIR_T);
        send_site(24'd4095, DIR_Z);
        send_site(24'd4096, DIR_X);
        send_site('1, DIR_Y);
        settle();
    endtask

    // zero acts as one, anything above the maximum as the maximum
    task automatic test_extent_limits();
        set_extents('0, '0, '0, '0);
        send_site(24'd0, DIR_X);
        send_site(24'd0, DIR_Y);
        send_site(24'd0, DIR_Z);
        send_site(24'd0, DIR_T);
        send_site(24'd1, DIR_T);
        settle();
        set_extents('1, '1, '1, '1);
        send_site('1, DIR_X);
        send_site('1, DIR_Y);
        send_site('1, DIR_Z);
        send_site('1, DIR_T);
        send_site(24'd0, DIR_T);
        settle();
    endtask

    // uneven lattice with a single-site axis
    task automatic test_mixed_extents();
        set_extents(7'd5, 7'd1, 7'd64, 7'd3);
        send_site(24'd959, DIR_Y);
        send_site(24'd959, DIR_Z);
        send_site(24'd4, DIR_X);
        send_site(24'd960, DIR_T);
        settle();
    endtask

    task automatic test_random_lattices();
        int idle_pcts [3] = '{24, 66, 0};
        foreach (idle_pcts[p])
        begin
            sender_idle_pct = idle_pcts[p];
            for (int s = 0; s < RANDOM_SETS; s++)
            begin
                set_extents(pick_extent(), pick_extent(), pick_extent(), pick_extent());
                repeat (SET_ITEMS)
                    send_site(pick_site(), DIR_W'($urandom));
                settle();
            end
        end
        sender_idle_pct = 0;
    endtask

    initial
    begin
        for (int i = 0; i < DIRECTIONS; i++)
            extent_reg[i] = EXTENT_RESET;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_extents();
        test_extent_limits();
        test_mixed_extents();
        test_random_lattices();

        $display("Covered %0d items (%0d outside the lattice) over %0d extent settings",
                 items_sent, outside_sent, settings_used);
        $display("Checked %0d results, %0d field mismatches", results_seen, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/plni_pkg.sv
rtl/plni_div_stage.sv
rtl/periodic_lattice_neighbor_index_unit.sv
tb/tb_periodic_lattice_neighbor_index_unit.sv
